// File: design/motor_feedback_multiturn_decode_core_defines.svh
// assertion helpers, sampled on clk and held off while arst_n is low
`ifndef MOTOR_FEEDBACK_MULTITURN_DECODE_CORE_DEFINES_SVH
`define MOTOR_FEEDBACK_MULTITURN_DECODE_CORE_DEFINES_SVH

// property must hold at every edge out of reset
`define MFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define MFD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: design/mfd_pkg.sv
package mfd_pkg;

	localparam logic [10:0] BASE_ID = 11'h201;
	localparam int MOTOR_IDX_MAX_W = 3;
	localparam logic [16:0] FULL_TURN = 17'd36000;
	localparam logic signed [16:0] HALF_TURN = 17'sd18000;
	localparam logic [25:0] CURRENT_SCALE = 26'd625;
	localparam int CURRENT_SHIFT = 11;
	localparam int OFFSET_REG_COUNT = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCOUNT_W = 2;
	localparam int TOTAL_W = 40;

	typedef struct packed {
		logic [10:0]        frame_id;
		logic [15:0]        angle_word;
		logic signed [15:0] speed_word;
		logic [15:0]        current_word;
	} frame_t;

	typedef struct packed {
		logic                        matched;
		logic [1:0]                  motor_index;
		logic [15:0]                 rotor_angle;
		logic signed [15:0]          speed_tenths;
		logic [14:0]                 current_milliamp;
		logic signed [23:0]          turn_count;
		logic signed [TOTAL_W-1:0]   total_angle;
	} result_t;

	// classified word passed from front to back
	typedef struct packed {
		logic                        matched;
		logic [MOTOR_IDX_MAX_W-1:0]  motor;
		logic [15:0]                 angle;
		logic signed [15:0]          speed;
		logic [14:0]                 cur_ma;
	} cls_t;

	typedef struct packed {
		logic                   we;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
	} cfg_wr_t;

endpackage

// File: design/mfd_if.sv
interface mfd_frame_if import mfd_pkg::*; ();
	logic   valid;
	logic   ready;
	frame_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface mfd_result_if import mfd_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: design/mfd_queue.sv
`include "motor_feedback_multiturn_decode_core_defines.svh"

module mfd_queue import mfd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_word,
	output logic full,
	input  logic pop,
	output logic avail,
	output cls_t pop_word
);

	cls_t                mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCOUNT_W-1:0] count_q;

	assign full     = (count_q == QCOUNT_W'(QUEUE_DEPTH));
	assign avail    = (count_q != '0);
	assign pop_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`MFD_ASSERT_NEVER(a_q_overfill, count_q > QCOUNT_W'(QUEUE_DEPTH), "queue count past depth")
	`MFD_ASSERT_NEVER(a_q_pop_empty, pop && !avail, "pop from empty queue")

endmodule

// File: design/mfd_front.sv
module mfd_front import mfd_pkg::*; #(
	parameter int MOTOR_COUNT = 4
) (
	mfd_frame_if.sink frame_in,
	input  logic      q_full,
	output logic      q_push,
	output cls_t      q_word
);

	logic [10:0] id_off;
	logic        matched;
	logic [25:0] cur_prod;

	assign id_off   = frame_in.data.frame_id - BASE_ID;
	assign matched  = (frame_in.data.frame_id >= BASE_ID) && (id_off < 11'(MOTOR_COUNT));
	assign cur_prod = 26'(frame_in.data.current_word) * CURRENT_SCALE;

	assign frame_in.ready = !q_full;
	assign q_push         = frame_in.valid && !q_full;

	// unmatched words go through with every field cleared
	always_comb begin
		q_word = '0;
		if (matched) begin
			q_word.matched = 1'b1;
			q_word.motor   = id_off[MOTOR_IDX_MAX_W-1:0];
			q_word.angle   = frame_in.data.angle_word;
			q_word.speed   = frame_in.data.speed_word;
			q_word.cur_ma  = cur_prod[CURRENT_SHIFT +: 15];
		end
	end

endmodule

// File: design/mfd_back.sv
`include "motor_feedback_multiturn_decode_core_defines.svh"

module mfd_back import mfd_pkg::*; #(
	parameter int MOTOR_COUNT = 4,
	parameter int TURN_WIDTH  = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_wr_t      cfg,
	input  logic         q_avail,
	input  cls_t         q_word,
	output logic         q_pop,
	mfd_result_if.source result_out
);

	localparam int IDX_W  = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
	localparam int PROD_W = TURN_WIDTH + 17;
	localparam int SUM_W  = (PROD_W + 1 > TOTAL_W) ? PROD_W + 1 : TOTAL_W;

	logic [CFG_DATA_W-1:0]   offset_q [OFFSET_REG_COUNT];
	logic [15:0]             prev_angle_q [MOTOR_COUNT];
	logic signed [TURN_WIDTH-1:0] turns_q [MOTOR_COUNT];

	logic                    v1_s1, v2_s2, v3_s3;
	logic                    en1, en2, en3;
	cls_t                    item_s1, item_s2;
	logic signed [TURN_WIDTH-1:0] turns_s1, turns_s2;
	logic [15:0]             offset_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [16:0]      ang_off_s2;
	result_t                 res_s3;

	logic [IDX_W-1:0]        m;
	logic [15:0]             prev_angle;
	logic signed [TURN_WIDTH-1:0] turns_cur, turns_next;
	logic signed [16:0]      jump;
	logic [15:0]             offset_sel;
	logic signed [PROD_W-1:0] prod;
	logic signed [SUM_W-1:0] sum;

	assign en3   = !v3_s3 || result_out.ready;
	assign en2   = !v2_s2 || en3;
	assign en1   = !v1_s1 || en2;
	assign q_pop = q_avail && en1;

	assign m          = q_word.motor[IDX_W-1:0];
	assign prev_angle = prev_angle_q[m];
	assign turns_cur  = turns_q[m];
	assign jump       = $signed({1'b0, q_word.angle}) - $signed({1'b0, prev_angle});
	assign offset_sel = q_word.motor[2] ? 16'd0 : offset_q[q_word.motor[1:0]];

	// a forward jump over half a turn is a wrap backwards, and vice versa
	always_comb begin
		turns_next = turns_cur;
		if (jump > HALF_TURN) begin
			turns_next = turns_cur - TURN_WIDTH'(1);
		end else if (jump < -HALF_TURN) begin
			turns_next = turns_cur + TURN_WIDTH'(1);
		end
	end

	assign prod = turns_s1 * $signed(FULL_TURN);
	assign sum  = SUM_W'(prod_s2) + SUM_W'(ang_off_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < OFFSET_REG_COUNT; k++) begin
				offset_q[k] <= '0;
			end
		end else if (cfg.we) begin
			offset_q[cfg.index] <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MOTOR_COUNT; k++) begin
				prev_angle_q[k] <= '0;
				turns_q[k]      <= '0;
			end
		end else if (q_pop && q_word.matched) begin
			prev_angle_q[m] <= q_word.angle;
			turns_q[m]      <= turns_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= q_avail;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1   <= q_word;
			turns_s1  <= q_word.matched ? turns_next : '0;
			offset_s1 <= q_word.matched ? offset_sel : 16'd0;
		end
		if (en2 && v1_s1) begin
			item_s2    <= item_s1;
			turns_s2   <= turns_s1;
			prod_s2    <= prod;
			ang_off_s2 <= $signed({1'b0, item_s1.angle}) - $signed({1'b0, offset_s1});
		end
		if (en3 && v2_s2) begin
			res_s3.matched          <= item_s2.matched;
			res_s3.motor_index      <= 2'(item_s2.motor);
			res_s3.rotor_angle      <= item_s2.angle;
			res_s3.speed_tenths     <= item_s2.speed;
			res_s3.current_milliamp <= item_s2.cur_ma;
			res_s3.turn_count       <= 24'(turns_s2);
			res_s3.total_angle      <= sum[TOTAL_W-1:0];
		end
	end

	assign result_out.valid = v3_s3;
	assign result_out.data  = res_s3;

	`MFD_ASSERT(a_b_unmatched_zero, (v3_s3 && !res_s3.matched) |-> (res_s3.total_angle == '0 && res_s3.turn_count == '0), "unmatched word carries state")
	`MFD_ASSERT_NEVER(a_b_motor_range, v1_s1 && item_s1.matched && (int'(item_s1.motor) >= MOTOR_COUNT), "motor index out of range")
	`MFD_ASSERT(a_b_advance, (v1_s1 && en2) |=> v2_s2, "stage one word lost")

endmodule

// File: design/motor_feedback_multiturn_decode_core.sv
// Multi-turn motor feedback decoder. Each frame word (identifier plus angle, speed and current
// words) gives exactly one result word, in order. Identifiers 0x201 up to 0x201+MOTOR_COUNT-1
// select a motor: the result carries the angle, speed, current in mA (raw*625/2048), the
// motor's turn count after wrap detection, and turns*36000 + angle - offset. Other identifiers
// give an all-zero result and leave the state alone. The block takes one word per clock while
// results are taken. The front writes a two-word queue, then three back stages follow: turn
// update as the word leaves the queue, multiply by 36000, final add. The rate is set by the
// per-motor read-modify-write of angle and turn count. Offset registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no word is in flight, as
// the block itself does not enforce it.
module motor_feedback_multiturn_decode_core import mfd_pkg::*; #(
	parameter int MOTOR_COUNT = 4,
	parameter int TURN_WIDTH  = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	mfd_frame_if.sink              frame_in,
	mfd_result_if.source           result_out,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic    q_push, q_full, q_pop, q_avail;
	cls_t    q_in_word, q_out_word;
	cfg_wr_t cfg;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	mfd_front #(
		.MOTOR_COUNT(MOTOR_COUNT)
	) u_front (
		.frame_in(frame_in),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_word  (q_in_word)
	);

	mfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_word(q_in_word),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.pop_word (q_out_word)
	);

	mfd_back #(
		.MOTOR_COUNT(MOTOR_COUNT),
		.TURN_WIDTH (TURN_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_avail   (q_avail),
		.q_word    (q_out_word),
		.q_pop     (q_pop),
		.result_out(result_out)
	);

endmodule

// File: tb/sv/motor_feedback_multiturn_decode_core_tb.sv
module motor_feedback_multiturn_decode_core_tb;
	import mfd_pkg::*;

	localparam int MOTORS = 4;
	localparam int HALF_REV = 18000;
	localparam int FULL_REV = 36000;
	localparam int SETTLE_CYCLES = 12;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int REPORT_LIMIT = 10;

	typedef enum logic [CFG_INDEX_W-1:0] {
		OFS_MOTOR_A,
		OFS_MOTOR_B,
		OFS_MOTOR_C,
		OFS_MOTOR_D
	} offset_reg_e;

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_THREE_IN_FOUR,
		READY_BLOCKS
	} ready_mode_e;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mfd_frame_if frame_bus();
	mfd_result_if result_bus();

	motor_feedback_multiturn_decode_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_in(frame_bus),
		.result_out(result_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [15:0] prior_angle [MOTORS];
	logic signed [23:0] turn_cnt [MOTORS];
	logic [15:0] angle_offset [MOTORS];
	result_t expected_results [$];

	int mismatch_count;
	int quiet_cycles;
	int burst_left;
	int spin_pos [MOTORS];
	int spin_dir [MOTORS];
	ready_mode_e ready_mode;
	int ready_left;
	int ready_phase;
	result_t want_result;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic result_t decode_frame(input frame_t f);
		result_t r;
		logic [1:0] m;
		int jump;
		longint whole;
		r = '0;
		if (f.frame_id < BASE_ID || f.frame_id >= BASE_ID + 11'(MOTORS))
			return r;
		m = 2'(f.frame_id - BASE_ID);
		jump = int'(f.angle_word) - int'(prior_angle[m]);
		if (jump > HALF_REV)
			turn_cnt[m] = turn_cnt[m] - 24'sd1;
		else if (jump < -HALF_REV)
			turn_cnt[m] = turn_cnt[m] + 24'sd1;
		prior_angle[m] = f.angle_word;
		whole = longint'(turn_cnt[m]) * FULL_REV + longint'(f.angle_word)
			- longint'(angle_offset[m]);
		r.matched = 1'b1;
		r.motor_index = m;
		r.rotor_angle = f.angle_word;
		r.speed_tenths = f.speed_word;
		r.current_milliamp = 15'((32'(f.current_word) * 32'd625) >> 11);
		r.turn_count = turn_cnt[m];
		r.total_angle = 40'(whole);
		return r;
	endfunction

	function automatic frame_t mk_frame(input logic [10:0] id, input logic [15:0] ang,
			input logic [15:0] spd, input logic [15:0] cur);
		frame_t f;
		f.frame_id = id;
		f.angle_word = ang;
		f.speed_word = spd;
		f.current_word = cur;
		return f;
	endfunction

	function automatic void report_mismatch(input string what, input result_t want,
			input result_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%s: expected m=%0d idx=%0d ang=%0d spd=%0d ma=%0d turns=%0d total=%0d, got m=%0d idx=%0d ang=%0d spd=%0d ma=%0d turns=%0d total=%0d",
				what, want.matched, want.motor_index, want.rotor_angle, want.speed_tenths,
				want.current_milliamp, want.turn_count, want.total_angle,
				got.matched, got.motor_index, got.rotor_angle, got.speed_tenths,
				got.current_milliamp, got.turn_count, got.total_angle);
	endfunction

	// one frame word, with a random gap at the start of each burst
	task automatic send_frame(input frame_t f);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				frame_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		frame_bus.valid <= 1'b1;
		frame_bus.data <= f;
		do
			@(posedge clk);
		while (!frame_bus.ready);
	endtask

	task automatic wait_idle();
		frame_bus.valid <= 1'b0;
		// let the last accepted word reach the predictor first
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic set_offsets(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c, input logic [15:0] d);
		logic [15:0] vals [MOTORS];
		vals = '{a, b, c, d};
		for (int k = 0; k < MOTORS; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= offset_reg_e'(k);
			cfg_data <= vals[k];
			angle_offset[k] = vals[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic test_unmatched_ids();
		send_frame(mk_frame(11'h000, 16'hffff, 16'hffff, 16'hffff));
		send_frame(mk_frame(BASE_ID - 11'd1, 16'd1234, 16'h8000, 16'd100));
		send_frame(mk_frame(BASE_ID + 11'(MOTORS), 16'd30000, 16'h7fff, 16'hffff));
		send_frame(mk_frame(11'h7ff, 16'h0000, 16'h0000, 16'h0000));
		send_frame(mk_frame(11'h5fe, 16'haaaa, 16'h5555, 16'hc3c3));
	endtask

	task automatic test_field_extremes();
		for (int m = 0; m < MOTORS; m++) begin
			send_frame(mk_frame(BASE_ID + 11'(m), 16'd0, 16'h7fff, 16'hffff));
			send_frame(mk_frame(BASE_ID + 11'(m), 16'hffff, 16'h8000, 16'h0000));
		end
	endtask

	// jumps either side of half a turn, on motor b, then a first frame each on motors c and d
	task automatic test_turn_wrap();
		logic [10:0] id;
		id = BASE_ID + 11'd1;
		send_frame(mk_frame(id, 16'd0, 16'd10, 16'd2048));
		send_frame(mk_frame(id, 16'd18000, 16'd10, 16'd2048));
		send_frame(mk_frame(id, 16'd0, 16'd10, 16'd2048));
		send_frame(mk_frame(id, 16'd18001, 16'd10, 16'd2048));
		send_frame(mk_frame(id, 16'd0, 16'd10, 16'd2048));
		send_frame(mk_frame(id, 16'd35999, 16'd10, 16'd2048));
		send_frame(mk_frame(id, 16'd100, 16'd10, 16'd2048));
		send_frame(mk_frame(BASE_ID + 11'd2, 16'd30000, 16'd5, 16'd7));
		send_frame(mk_frame(BASE_ID + 11'd3, 16'd65535, 16'd5, 16'd7));
	endtask

	// motors turning in mostly steady directions, with noise and odd jumps mixed in
	task automatic test_random_rotation(input int count);
		frame_t f;
		int m;
		int step;
		int ang;
		for (int i = 0; i < count; i++) begin
			f.speed_word = 16'($urandom);
			f.current_word = ($urandom_range(0, 19) == 0) ? 16'hffff : 16'($urandom);
			if ($urandom_range(0, 99) < 12) begin
				case ($urandom_range(0, 3))
					0: f.frame_id = BASE_ID - 11'd1;
					1: f.frame_id = BASE_ID + 11'(MOTORS);
					default: f.frame_id = 11'($urandom);
				endcase
				f.angle_word = 16'($urandom);
			end else begin
				m = $urandom_range(0, MOTORS - 1);
				if ($urandom_range(0, 49) == 0)
					spin_dir[m] = -spin_dir[m];
				case ($urandom_range(0, 9))
					0: ang = $urandom_range(0, 65535);
					1: begin
						step = $urandom_range(17000, 19000);
						ang = ((spin_pos[m] + spin_dir[m] * step) % FULL_REV + FULL_REV)
							% FULL_REV;
					end
					default: begin
						step = $urandom_range(0, 4000);
						ang = ((spin_pos[m] + spin_dir[m] * step) % FULL_REV + FULL_REV)
							% FULL_REV;
					end
				endcase
				spin_pos[m] = ang;
				f.frame_id = BASE_ID + 11'(m);
				f.angle_word = 16'(ang);
			end
			send_frame(f);
		end
	endtask

	// predict on every accepted frame word
	always @(posedge clk) begin
		if (arst_n && frame_bus.valid && frame_bus.ready)
			expected_results.push_back(decode_frame(frame_bus.data));
	end

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result word", '0, result_bus.data);
			end else begin
				want_result = expected_results.pop_front();
				if (result_bus.data.matched !== want_result.matched
						|| result_bus.data.motor_index !== want_result.motor_index
						|| result_bus.data.rotor_angle !== want_result.rotor_angle
						|| result_bus.data.speed_tenths !== want_result.speed_tenths
						|| result_bus.data.current_milliamp !== want_result.current_milliamp
						|| result_bus.data.turn_count !== want_result.turn_count
						|| result_bus.data.total_angle !== want_result.total_angle)
					report_mismatch("result mismatch", want_result, result_bus.data);
			end
		end
	end

	// receiver stalls, switching pattern every so often
	always @(posedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (ready_left == 0) begin
				ready_mode = ready_mode_e'($urandom_range(0, 3));
				ready_left = $urandom_range(20, 200);
			end
			ready_left--;
			ready_phase++;
			case (ready_mode)
				READY_ALWAYS: result_bus.ready <= 1'b1;
				READY_COIN: result_bus.ready <= 1'($urandom_range(0, 1));
				READY_THREE_IN_FOUR: result_bus.ready <= (ready_phase % 4) != 3;
				default: result_bus.ready <= (ready_phase % 16) < 6;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((frame_bus.valid && frame_bus.ready) || (result_bus.valid && result_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("motor_feedback_multiturn_decode_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		frame_bus.valid = 1'b0;
		frame_bus.data = '0;
		result_bus.ready = 1'b0;
		mismatch_count = 0;
		quiet_cycles = 0;
		burst_left = 0;
		ready_left = 0;
		ready_phase = 0;
		ready_mode = READY_ALWAYS;
		for (int k = 0; k < MOTORS; k++) begin
			prior_angle[k] = '0;
			turn_cnt[k] = '0;
			angle_offset[k] = '0;
			spin_pos[k] = 0;
			spin_dir[k] = (k % 2 == 0) ? 1 : -1;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unmatched_ids();
		test_field_extremes();
		test_turn_wrap();
		wait_idle();
		set_offsets(16'd36000, 16'd0, 16'hffff, 16'd18000);
		test_random_rotation(340);
		wait_idle();
		set_offsets(16'($urandom_range(0, FULL_REV)), 16'($urandom_range(0, FULL_REV)),
			16'($urandom_range(0, FULL_REV)), 16'($urandom_range(0, FULL_REV)));
		test_random_rotation(330);
		wait_idle();
		set_offsets(16'd0, 16'd36000, 16'($urandom), 16'd1);
		test_random_rotation(330);
		wait_idle();

		if (mismatch_count == 0)
			$display("motor_feedback_multiturn_decode_core verification clean");
		else
			$display("motor_feedback_multiturn_decode_core verification failed");
		$finish;
	end

endmodule
